>>> design/lsdp_pkg.sv
`default_nettype none

package lsdp_pkg;

    // Stack geometry and storage widths
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_BITS   = 48;
    localparam int COUNT_BITS  = 48;
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    // Port field widths
    localparam int CAP_W    = 7;
    localparam int QSIZE_W  = 7;
    localparam int PAGE_W   = 48;
    localparam int DIST_W   = 6;
    localparam int SUCC_W   = 48;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 104;

    // Input item kinds (tuser)
    localparam logic MODE_ACCESS = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    // Controls from the sequencer into the cell chain
    typedef struct packed {
        logic [ADDR_BITS-1:0] key;
        logic                 capture;
        logic                 commit;
        logic [CAP_W-1:0]     cap;
        logic                 drop;
        logic [CAP_W-1:0]     new_cap;
        logic [IDX_W-1:0]     qidx;
    } chain_ctl_t;

    // Registered lookup results and status from the cell chain
    typedef struct packed {
        logic [STACK_DEPTH-1:0] valid;
        logic [STACK_DEPTH-1:0] match;
        logic                   hit;
        logic [IDX_W-1:0]       hit_rank;
        logic                   full;
        logic [ADDR_BITS-1:0]   evict_addr;
        logic [COUNT_BITS-1:0]  qcount;
    } chain_stat_t;

    // Capacity 0 acts as 1, anything above the depth acts as the depth
    function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
        logic [CAP_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CAP_W'(1);
        end else if (v > CAP_W'(STACK_DEPTH)) begin
            r = CAP_W'(STACK_DEPTH);
        end
        return r;
    endfunction

    // Index of the set bit in a one-hot (or zero) vector
    function automatic logic [IDX_W-1:0] onehot_index(input logic [STACK_DEPTH-1:0] oh);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            if (oh[i]) begin
                r = r | IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/lsdp_cell.sv
`default_nettype none

module lsdp_cell import lsdp_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [ADDR_BITS-1:0]  key,
    input  wire logic                  commit,
    input  wire logic                  drop,
    input  wire logic                  shift_en,
    input  wire logic                  inc,
    input  wire logic [ADDR_BITS-1:0]  prev_addr,
    input  wire logic                  prev_valid,
    output logic [ADDR_BITS-1:0]       addr,
    output logic                       valid,
    output logic                       match,
    output logic [COUNT_BITS-1:0]      count
);

    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic                  valid_reg, valid_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    // Entry takes its upper neighbor's page on a shift; config drop wins
    always_comb begin
        addr_next  = addr_reg;
        valid_next = valid_reg;
        if (commit && shift_en) begin
            addr_next  = prev_addr;
            valid_next = prev_valid;
        end
        if (drop) begin
            valid_next = 1'b0;
        end
    end

    // Saturating success counter
    always_comb begin
        cnt_next = cnt_reg;
        if (commit && inc && !(&cnt_reg)) begin
            cnt_next = cnt_reg + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign addr  = addr_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (addr_reg == key);
    assign count = cnt_reg;

endmodule

`default_nettype wire

>>> design/lsdp_chain.sv
`default_nettype none

module lsdp_chain import lsdp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire chain_ctl_t  ctl,
    output chain_stat_t      stat
);

    logic [ADDR_BITS-1:0]  addr_arr [STACK_DEPTH];
    logic [COUNT_BITS-1:0] cnt_arr  [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] valid_vec;
    logic [STACK_DEPTH-1:0] match_vec;
    logic [STACK_DEPTH-1:0] shift_vec;
    logic [STACK_DEPTH-1:0] drop_vec;
    logic [STACK_DEPTH-1:0] ge_vec;

    logic [STACK_DEPTH-1:0] match_reg;
    logic                   full_reg;
    logic [ADDR_BITS-1:0]   evict_reg;
    logic [COUNT_BITS-1:0]  qcount_reg;
    logic [IDX_W-1:0]       bottom_idx;

    // Cells at or below the hit rank; empty on a miss
    assign ge_vec = ~(match_reg - STACK_DEPTH'(1));

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [ADDR_BITS-1:0] prev_addr;
        logic                 prev_valid;

        if (i == 0) begin : g_top
            assign prev_addr  = ctl.key;
            assign prev_valid = 1'b1;
        end else begin : g_lower
            assign prev_addr  = addr_arr[i-1];
            assign prev_valid = valid_vec[i-1];
        end

        // Shift the hit rank and the ranks above it (all ranks on a miss), within capacity
        assign shift_vec[i] = (!ge_vec[i] || match_reg[i]) && (CAP_W'(i) < ctl.cap);
        assign drop_vec[i]  = ctl.drop && (CAP_W'(i) >= ctl.new_cap);

        lsdp_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .key        (ctl.key),
            .commit     (ctl.commit),
            .drop       (drop_vec[i]),
            .shift_en   (shift_vec[i]),
            .inc        (ge_vec[i]),
            .prev_addr  (prev_addr),
            .prev_valid (prev_valid),
            .addr       (addr_arr[i]),
            .valid      (valid_vec[i]),
            .match      (match_vec[i]),
            .count      (cnt_arr[i])
        );
    end

    assign bottom_idx = IDX_W'(ctl.cap - CAP_W'(1));

    // Lookup stage: register compare results, bottom entry and queried counter
    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            match_reg  <= match_vec;
            full_reg   <= valid_vec[bottom_idx];
            evict_reg  <= addr_arr[bottom_idx];
            qcount_reg <= cnt_arr[ctl.qidx];
        end
    end

    assign stat.valid      = valid_vec;
    assign stat.match      = match_reg;
    assign stat.hit        = |match_reg;
    assign stat.hit_rank   = onehot_index(match_reg);
    assign stat.full       = full_reg;
    assign stat.evict_addr = evict_reg;
    assign stat.qcount     = qcount_reg;

endmodule

`default_nettype wire

>>> design/lru_stack_distance_profiler.sv
// A result is registered on m_tdata after the compare step and then the update step.
// A new item is taken only as the last one completes its update: the compare step is followed
// by the cell chain's shift/count step; a stalled output holds the chain in its update step.
// Reset (aresetn low, synchronous): stack valid bits and all success counters cleared
// at once, capacity set to 64 pages, no clearing pass; addresses are not reset.
`default_nettype none

module lru_stack_distance_profiler import lsdp_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // tdata: page_address[47:0], query_size[54:48], zero pad [55]
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // tuser: mode
    input  wire logic                 s_tuser,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // tdata: hit[0], stack_distance[6:1], evicted[7], evicted_address[55:8],
    //        success_count[103:56]
    output logic [M_DATA_W-1:0]       m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_we,
    input  wire logic [CAP_W-1:0]     cfg_wdata
);

    state_t state_reg, state_next;

    logic                  mode_reg;
    logic [ADDR_BITS-1:0]  key_reg;
    logic [IDX_W-1:0]      qidx_reg;
    logic                  qzero_reg;
    logic [CAP_W-1:0]      cap_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg;

    logic                  s_xfer;
    logic                  commit;
    logic [PAGE_W-1:0]     in_page;
    logic [QSIZE_W-1:0]    in_qsize;
    logic [QSIZE_W-1:0]    qclamp;

    logic                  r_hit;
    logic [DIST_W-1:0]     r_dist;
    logic                  r_evicted;
    logic [PAGE_W-1:0]     r_evict_addr;
    logic [SUCC_W-1:0]     r_count;

    chain_ctl_t  ctl;
    chain_stat_t stat;

    assign in_page  = s_tdata[PAGE_W-1:0];
    assign in_qsize = s_tdata[PAGE_W +: QSIZE_W];

    // Update step completes once the output register can take the result
    assign commit   = (state_reg == ST_UPD) && (!m_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE) || commit;
    assign s_xfer   = s_tvalid && s_tready;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (commit) begin
                    state_next = s_tvalid ? ST_CMP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Input item registers
    assign qclamp = (in_qsize > QSIZE_W'(STACK_DEPTH)) ? QSIZE_W'(STACK_DEPTH) : in_qsize;

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            mode_reg  <= s_tuser;
            key_reg   <= ADDR_BITS'(in_page);
            qidx_reg  <= IDX_W'(qclamp - QSIZE_W'(1));
            qzero_reg <= (in_qsize == '0);
        end
    end

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_W'(STACK_DEPTH);
        end else if (cfg_we) begin
            cap_reg <= clamp_cap(cfg_wdata);
        end
    end

    assign ctl.key     = key_reg;
    assign ctl.capture = (state_reg == ST_CMP);
    assign ctl.commit  = commit && (mode_reg == MODE_ACCESS);
    assign ctl.cap     = cap_reg;
    assign ctl.drop    = cfg_we;
    assign ctl.new_cap = clamp_cap(cfg_wdata);
    assign ctl.qidx    = qidx_reg;

    lsdp_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .stat    (stat)
    );

    // Result fields; unused fields read as zero
    always_comb begin
        r_hit        = 1'b0;
        r_dist       = '0;
        r_evicted    = 1'b0;
        r_evict_addr = '0;
        r_count      = '0;
        if (mode_reg == MODE_QUERY) begin
            if (!qzero_reg) begin
                r_count = SUCC_W'(stat.qcount);
            end
        end else begin
            r_hit = stat.hit;
            if (stat.hit) begin
                r_dist = DIST_W'(stat.hit_rank);
            end else if (stat.full) begin
                r_evicted    = 1'b1;
                r_evict_addr = PAGE_W'(stat.evict_addr);
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= {r_count, r_evict_addr, r_evicted, r_dist, r_hit};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Valid entries form an unbroken run from the top of the stack
    a_valid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ((stat.valid >> 1) & ~stat.valid) == '0)
        else $error("stack valid bits not contiguous");

    // A page is held at most once, so at most one cell matches
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> $onehot0(stat.match))
        else $error("more than one cell matched");

    // A completed update always leaves a result in the output register
    a_commit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_tvalid)
        else $error("update without result");

endmodule

`default_nettype wire

>>> tb/sv/lsdp_tb_pkg.sv
`default_nettype none

package lsdp_tb_pkg;
    import lsdp_pkg::*;

    // One result as the block reports it
    typedef struct {
        logic                hit;
        logic [DIST_W-1:0]   hit_rank;
        logic                evicted;
        logic [PAGE_W-1:0]   evict_addr;
        logic [SUCC_W-1:0]   count;
    } profile_result_t;

    class lru_profile_scoreboard;
        logic [ADDR_BITS-1:0]  page_stack[STACK_DEPTH];
        bit                    page_valid[STACK_DEPTH];
        logic [COUNT_BITS-1:0] hit_counts[STACK_DEPTH];
        logic [CAP_W-1:0]      pages_in_use;
        profile_result_t       expected_results[$];
        int                    mismatches;

        // State right after reset
        function void clear();
            for (int i = 0; i < STACK_DEPTH; i++) begin
                page_stack[i] = '0;
                page_valid[i] = 1'b0;
                hit_counts[i] = '0;
            end
            pages_in_use = CAP_W'(STACK_DEPTH);
            mismatches = 0;
            expected_results.delete();
        endfunction

        // Effective number of frames: 0 acts as 1, above the depth acts as the depth
        function int frames();
            if (pages_in_use == '0) return 1;
            if (pages_in_use > CAP_W'(STACK_DEPTH)) return STACK_DEPTH;
            return int'(pages_in_use);
        endfunction

        // Shrinking drops every page at or past the new capacity; counters stay
        function void set_capacity(logic [CAP_W-1:0] v);
            pages_in_use = v;
            for (int i = frames(); i < STACK_DEPTH; i++) page_valid[i] = 1'b0;
        endfunction

        // Ranks 0..n-1 move down one, page goes to rank 0
        function void move_to_top(int n, logic [ADDR_BITS-1:0] page);
            for (int i = n; i > 0; i--) begin
                page_stack[i] = page_stack[i-1];
                page_valid[i] = page_valid[i-1];
            end
            page_stack[0] = page;
            page_valid[0] = 1'b1;
        endfunction

        // Accepted input transfer: update the stack and queue the expected result
        function void note_request(logic mode, logic [PAGE_W-1:0] page,
                                   logic [QSIZE_W-1:0] qsize);
            profile_result_t r;
            int cap;
            int used;
            int q;
            bit found;
            r.hit = 1'b0;
            r.hit_rank = '0;
            r.evicted = 1'b0;
            r.evict_addr = '0;
            r.count = '0;
            cap = frames();
            if (mode == MODE_QUERY) begin
                if (qsize != '0) begin
                    q = (qsize > QSIZE_W'(STACK_DEPTH)) ? STACK_DEPTH : int'(qsize);
                    r.count = hit_counts[q-1];
                end
            end else begin
                used = 0;
                while (used < cap && page_valid[used]) used++;
                found = 1'b0;
                for (int i = 0; i < used && !found; i++) begin
                    if (page_stack[i] == page) begin
                        found = 1'b1;
                        r.hit = 1'b1;
                        r.hit_rank = DIST_W'(i);
                        move_to_top(i, page);
                        // a hit at distance i counts for every size above i
                        for (int k = i; k < STACK_DEPTH; k++) begin
                            if (hit_counts[k] != '1) hit_counts[k]++;
                        end
                    end
                end
                if (!found) begin
                    if (used >= cap) begin
                        r.evicted = 1'b1;
                        r.evict_addr = page_stack[cap-1];
                        move_to_top(cap - 1, page);
                    end else begin
                        move_to_top(used, page);
                    end
                end
            end
            expected_results.push_back(r);
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t mismatch on %s: expected %h, got %h", $time, field, want, got);
            end
        endfunction

        // Accepted output transfer: compare against the oldest expectation
        function void check_result(logic [M_DATA_W-1:0] data);
            profile_result_t want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t result with nothing expected: %h", $time, data);
                return;
            end
            want = expected_results[0];
            expected_results.delete(0);
            report("hit", want.hit, data[0]);
            report("stack_distance", want.hit_rank, data[6:1]);
            report("evicted", want.evicted, data[7]);
            report("evicted_address", want.evict_addr, data[55:8]);
            report("success_count", want.count, data[103:56]);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lsdp_pkg::*;
    import lsdp_tb_pkg::*;

    localparam int POOL_SIZE   = 96;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 10;

    logic                aclk;
    logic                aresetn;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                s_tvalid;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic                cfg_we;
    logic [CAP_W-1:0]    cfg_wdata;

    lru_profile_scoreboard sb;
    logic [PAGE_W-1:0]     page_pool[POOL_SIZE];
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    holdoff_left;
    int                    cycles;

    lru_stack_distance_profiler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: long hold-off when requested, otherwise random stalls
    always @(negedge aclk) begin
        if (holdoff_left > 0) begin
            m_tready <= 1'b0;
            holdoff_left = holdoff_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [PAGE_W-1:0] random_page();
        return PAGE_W'({$urandom, $urandom});
    endfunction

    // One input transfer, preceded by a random idle gap
    task automatic send_item(input logic mode, input logic [PAGE_W-1:0] page,
                             input logic [QSIZE_W-1:0] qsize);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, qsize, page};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(mode, page, qsize);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        drain_results();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.set_capacity(v);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random traffic: pool accesses with locality, repeated sweeps, queries, fresh pages
    task automatic run_phase(input int n_items, input int cap);
        int sent;
        int span;
        int pick;
        int sweep_len;
        span = cap + cap / 4 + 2;
        if (span > POOL_SIZE) span = POOL_SIZE;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                send_item(MODE_QUERY, random_page(), QSIZE_W'($urandom_range(127)));
                sent++;
            end else if (pick < 20) begin
                send_item(MODE_ACCESS, random_page(), QSIZE_W'($urandom_range(127)));
                sent++;
            end else if (pick < 28) begin
                // two passes over the same pages: second pass hits at len-1 unless len is cap+1
                sweep_len = $urandom_range(cap + 1, 1);
                repeat (2) begin
                    for (int j = 0; j < sweep_len; j++)
                        send_item(MODE_ACCESS, page_pool[j], QSIZE_W'($urandom_range(127)));
                end
                sent += 2 * sweep_len;
            end else begin
                send_item(MODE_ACCESS, page_pool[$urandom_range(span - 1)],
                          QSIZE_W'($urandom_range(127)));
                sent++;
            end
        end
    endtask

    initial begin
        logic [CAP_W-1:0] phase_caps[PHASES];
        int eff;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = MODE_ACCESS;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        aresetn        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_left   = 0;
        cycles         = 0;
        phase_caps = '{7'd127, 7'd8, 7'd2, 7'd64, 7'd0, 7'd20, 7'd64, 7'd5, 7'd100, 7'd33};
        sb = new();
        sb.clear();
        page_pool[0] = '0;
        page_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = random_page();

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: counters empty, size zero and oversized queries
        send_item(MODE_QUERY, '0, 7'd0);
        send_item(MODE_QUERY, '1, 7'd1);
        send_item(MODE_QUERY, '0, 7'd64);
        send_item(MODE_QUERY, '0, 7'd127);
        // extreme addresses, hits at distance one and zero
        send_item(MODE_ACCESS, '0, 7'd127);
        send_item(MODE_ACCESS, '1, 7'd0);
        send_item(MODE_ACCESS, '0, 7'd64);
        send_item(MODE_ACCESS, '0, 7'd1);
        send_item(MODE_ACCESS, '1, 7'd0);
        send_item(MODE_ACCESS, 48'h5555_5555_5555, 7'h55);
        send_item(MODE_ACCESS, 48'hAAAA_AAAA_AAAA, 7'h2A);
        send_item(MODE_QUERY, '0, 7'd1);
        send_item(MODE_QUERY, '0, 7'd2);
        send_item(MODE_QUERY, '0, 7'd64);
        send_item(MODE_QUERY, '1, 7'd65);
        // single frame: shrink drops pages, every miss after the first evicts
        write_capacity(7'd1);
        send_item(MODE_ACCESS, 48'h0000_0000_1234, 7'd0);
        send_item(MODE_ACCESS, 48'h0000_0000_5678, 7'd0);
        send_item(MODE_ACCESS, 48'h0000_0000_5678, 7'd0);
        send_item(MODE_QUERY, '0, 7'd1);
        // three frames: fill, evict the bottom, hit at the deepest rank
        write_capacity(7'd3);
        send_item(MODE_ACCESS, 48'h1, 7'd0);
        send_item(MODE_ACCESS, 48'h2, 7'd0);
        send_item(MODE_ACCESS, 48'h3, 7'd0);
        send_item(MODE_ACCESS, 48'h4, 7'd0);
        send_item(MODE_ACCESS, 48'h2, 7'd0);

        // Random phases, one capacity and one idling pattern each
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(phase_caps[p]);
            eff = (phase_caps[p] == '0) ? 1 :
                  (phase_caps[p] > CAP_W'(STACK_DEPTH)) ? STACK_DEPTH : int'(phase_caps[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (p == 4) begin
                // receiver holds off while the sender keeps pushing
                run_phase(40, eff);
                holdoff_left = 300;
                run_phase(63, eff);
            end else if (p == 6) begin
                run_phase(50, eff);
                drain_results();
                run_phase(53, eff);
            end else begin
                run_phase(103, eff);
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
